[rtl/dvrt_pkg.sv]
// Shared widths, controller states and command/status types of the daily VWAP tracker.
`timescale 1ns / 1ps

package dvrt_pkg;

    localparam int DAY_W   = 16;
    localparam int PRICE_W = 25;
    localparam int VOL_W   = 30;
    localparam int TP_W    = 26;   // sum of three non-negative 24-bit prices
    localparam int PROD_W  = TP_W + VOL_W;
    localparam int PV_W    = 63;
    localparam int VS_W    = 37;
    localparam int DIV_W   = VS_W + 2;  // three times the volume sum
    localparam int VWAP_W  = 24;
    localparam int CNT_W   = 5;

    // Quotient fits in VWAP_W bits, so the divider runs one step per quotient bit
    localparam logic [CNT_W-1:0] DIV_FIRST_STEP = CNT_W'(VWAP_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST_STEP  = '0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SUM,
        S_DIVLD,
        S_DIV,
        S_UPD,
        S_DONE
    } dvrt_state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic sum;
        logic div_load;
        logic div_step;
        logic update;
        logic load_out;
    } dvrt_cmd_t;

    typedef struct packed {
        logic skip;
        logic ovf;
        logic div_last;
        logic out_free;
    } dvrt_sts_t;

endpackage

[rtl/dvrt_channels.sv]
// Candle input and statistics output channel interfaces.
`timescale 1ns / 1ps

interface dvrt_candle_if;
    import dvrt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic        [DAY_W-1:0]   day;
    logic signed [PRICE_W-1:0] high_price;
    logic signed [PRICE_W-1:0] low_price;
    logic signed [PRICE_W-1:0] close_price;
    logic        [VOL_W-1:0]   volume;
    logic                      restart;

    modport source (output valid, day, high_price, low_price, close_price, volume, restart,
                    input ready);
    modport sink   (input valid, day, high_price, low_price, close_price, volume, restart,
                    output ready);
endinterface

interface dvrt_stats_if;
    import dvrt_pkg::*;

    logic              valid;
    logic              ready;
    logic [VWAP_W-1:0] vwap_high;
    logic [VWAP_W-1:0] vwap_low;
    logic [VWAP_W-1:0] vwap_close;
    logic              stats_valid;
    logic              candle_used;

    modport source (output valid, vwap_high, vwap_low, vwap_close, stats_valid, candle_used,
                    input ready);
    modport sink   (input valid, vwap_high, vwap_low, vwap_close, stats_valid, candle_used,
                    output ready);
endinterface

[rtl/daily_vwap_range_tracker.sv]
// Top level of the daily VWAP range tracker: controller, datapath and channel wiring.
//
//   channel     dir   handshake           payload
//   candle_in   in    valid / ready       day, high_price, low_price, close_price, volume, restart
//   stats_out   out   valid / ready       vwap_high, vwap_low, vwap_close, stats_valid, candle_used
//   cfg         in    cfg_we (no ready)   cfg_wdata = target_day
//
// A candle that enters the sums passes from accept to the next accept through capture,
// check, multiply, accumulate, divisor setup, 24 divider steps, update and result load.
// A skipped candle goes from check to result load; an overflow of the sums, from accumulate.
// A finished result word sits in an output register; the block waits in its last state only
// while that register is full and not taken. Reset clears sums, flags and target day.
`timescale 1ns / 1ps

module daily_vwap_range_tracker
    import dvrt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [DAY_W-1:0]   cfg_wdata,
    dvrt_candle_if.sink        candle_in,
    dvrt_stats_if.source       stats_out
);

    dvrt_cmd_t cmd;
    dvrt_sts_t sts;

    // Sequence each candle word
    dvrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (candle_in.valid),
        .in_ready (candle_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Compute sums, quotient and result word
    dvrt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .day         (candle_in.day),
        .high_price  (candle_in.high_price),
        .low_price   (candle_in.low_price),
        .close_price (candle_in.close_price),
        .volume      (candle_in.volume),
        .restart     (candle_in.restart),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (stats_out.valid),
        .out_ready   (stats_out.ready),
        .vwap_high   (stats_out.vwap_high),
        .vwap_low    (stats_out.vwap_low),
        .vwap_close  (stats_out.vwap_close),
        .stats_valid (stats_out.stats_valid),
        .candle_used (stats_out.candle_used)
    );

endmodule

[rtl/dvrt_ctrl.sv]
// Sequencing state machine of the daily VWAP tracker.
`timescale 1ns / 1ps

module dvrt_ctrl
    import dvrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dvrt_sts_t sts,
    output dvrt_cmd_t cmd
);

    dvrt_state_t state_reg;
    dvrt_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Pick next state and issue datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.skip ? S_DONE : S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = sts.ovf ? S_DONE : S_DIVLD;
            end
            S_DIVLD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // At most one datapath command per cycle
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("dvrt_ctrl: several commands at once");

    // A skipped candle goes straight to the result
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && sts.skip) |=> (state_reg == S_DONE))
        else $error("dvrt_ctrl: skipped candle entered the sums");

    // The divider finishes before the running values update
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> ($past(state_reg) == S_DIV))
        else $error("dvrt_ctrl: update without division");

endmodule

[rtl/dvrt_dp.sv]
// Datapath of the daily VWAP tracker: sums, multiplier, restoring divider, result word.
`timescale 1ns / 1ps

module dvrt_dp
    import dvrt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic        [DAY_W-1:0]   cfg_wdata,
    input  logic        [DAY_W-1:0]   day,
    input  logic signed [PRICE_W-1:0] high_price,
    input  logic signed [PRICE_W-1:0] low_price,
    input  logic signed [PRICE_W-1:0] close_price,
    input  logic        [VOL_W-1:0]   volume,
    input  logic                      restart,
    input  dvrt_cmd_t                 cmd,
    output dvrt_sts_t                 sts,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic        [VWAP_W-1:0]  vwap_high,
    output logic        [VWAP_W-1:0]  vwap_low,
    output logic        [VWAP_W-1:0]  vwap_close,
    output logic                      stats_valid,
    output logic                      candle_used
);

    logic [DAY_W-1:0]  target_day_reg;

    logic [DAY_W-1:0]  day_reg;
    logic [TP_W-1:0]   tp_reg;
    logic [VOL_W-1:0]  vol_reg;
    logic              wf_reg;
    logic [PROD_W-1:0] prod_reg;

    logic [PV_W-1:0]   pv_sum_reg;
    logic [VS_W-1:0]   vs_sum_reg;
    logic [VWAP_W-1:0] run_high_reg;
    logic [VWAP_W-1:0] run_low_reg;
    logic [VWAP_W-1:0] run_close_reg;
    logic              any_used_reg;
    logic              past_target_reg;
    logic              used_reg;

    logic [PV_W-1:0]   rem_reg;
    logic [PV_W-1:0]   dsr_reg;
    logic [VWAP_W-1:0] quo_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic              out_valid_reg;
    logic [VWAP_W-1:0] out_high_reg;
    logic [VWAP_W-1:0] out_low_reg;
    logic [VWAP_W-1:0] out_close_reg;
    logic              out_stats_reg;
    logic              out_used_reg;

    logic [TP_W-1:0]   tp_next;
    logic              wf_next;
    logic [PROD_W-1:0] prod_next;
    logic [PV_W:0]     pv_next;
    logic [VS_W:0]     vs_next;
    logic [DIV_W-1:0]  div_next;
    logic              rem_ge;

    // Typical price and candle sanity checks on the incoming word
    assign tp_next = TP_W'(high_price[VWAP_W-1:0]) + TP_W'(low_price[VWAP_W-1:0])
                   + TP_W'(close_price[VWAP_W-1:0]);
    assign wf_next = (volume != '0) && (high_price >= low_price)
                   && !low_price[PRICE_W-1] && !close_price[PRICE_W-1];

    assign prod_next = PROD_W'(tp_reg) * PROD_W'(vol_reg);
    assign pv_next   = {1'b0, pv_sum_reg} + (PV_W + 1)'(prod_reg);
    assign vs_next   = {1'b0, vs_sum_reg} + (VS_W + 1)'(vol_reg);
    assign div_next  = {2'b00, vs_sum_reg} + {1'b0, vs_sum_reg, 1'b0};
    assign rem_ge    = (rem_reg >= dsr_reg);

    // Report status to the controller
    assign sts.skip     = past_target_reg || (day_reg != target_day_reg) || !wf_reg;
    assign sts.ovf      = pv_next[PV_W] || vs_next[VS_W];
    assign sts.div_last = (cnt_reg == DIV_LAST_STEP);
    assign sts.out_free = !out_valid_reg || out_ready;

    // Hold the target day register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_day_reg <= '0;
        end
        else if (cfg_we)
        begin
            target_day_reg <= cfg_wdata;
        end
    end

    // Capture the candle word and form the product
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            day_reg <= day;
            tp_reg  <= tp_next;
            vol_reg <= volume;
            wf_reg  <= wf_next;
        end
        if (cmd.eval)
        begin
            prod_reg <= prod_next;
        end
    end

    // Accumulate, track the running values, clear on restart
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_sum_reg      <= '0;
            vs_sum_reg      <= '0;
            run_high_reg    <= '0;
            run_low_reg     <= '1;
            run_close_reg   <= '0;
            any_used_reg    <= 1'b0;
            past_target_reg <= 1'b0;
            used_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                used_reg <= 1'b0;
                if (restart)
                begin
                    pv_sum_reg      <= '0;
                    vs_sum_reg      <= '0;
                    run_high_reg    <= '0;
                    run_low_reg     <= '1;
                    run_close_reg   <= '0;
                    any_used_reg    <= 1'b0;
                    past_target_reg <= 1'b0;
                end
            end
            // Latch the end of the target day once a later day shows up
            if (cmd.eval && !past_target_reg && any_used_reg && (day_reg > target_day_reg))
            begin
                past_target_reg <= 1'b1;
            end
            if (cmd.sum && !sts.ovf)
            begin
                pv_sum_reg   <= pv_next[PV_W-1:0];
                vs_sum_reg   <= vs_next[VS_W-1:0];
                any_used_reg <= 1'b1;
                used_reg     <= 1'b1;
            end
            if (cmd.update)
            begin
                run_close_reg <= quo_reg;
                if (quo_reg > run_high_reg)
                begin
                    run_high_reg <= quo_reg;
                end
                if (quo_reg < run_low_reg)
                begin
                    run_low_reg <= quo_reg;
                end
            end
        end
    end

    // Restoring divider: one quotient bit per cycle, MSB first
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg <= pv_sum_reg;
            dsr_reg <= {1'b0, div_next, {(VWAP_W - 1){1'b0}}};
            quo_reg <= '0;
            cnt_reg <= DIV_FIRST_STEP;
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - dsr_reg;
            end
            dsr_reg <= dsr_reg >> 1;
            quo_reg <= {quo_reg[VWAP_W-2:0], rem_ge};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_high_reg  <= run_high_reg;
            out_low_reg   <= any_used_reg ? run_low_reg : '0;
            out_close_reg <= run_close_reg;
            out_stats_reg <= any_used_reg;
            out_used_reg  <= used_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign vwap_high   = out_high_reg;
    assign vwap_low    = out_low_reg;
    assign vwap_close  = out_close_reg;
    assign stats_valid = out_stats_reg;
    assign candle_used = out_used_reg;

    // Sums stay empty while nothing has been used
    assert property (@(posedge clk) disable iff (!rst_n)
        !any_used_reg |-> (vs_sum_reg == '0 && pv_sum_reg == '0))
        else $error("dvrt_dp: sums nonzero with nothing used");

    // Divisor is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |-> (vs_sum_reg != '0))
        else $error("dvrt_dp: division by zero volume");

    // A used candle marks the statistics valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sum && !sts.ovf) |=> (any_used_reg && used_reg))
        else $error("dvrt_dp: committed candle not flagged");

    // Presented range is ordered
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stats_reg) |-> (out_low_reg <= out_high_reg))
        else $error("dvrt_dp: running low above running high");

endmodule
